[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);

`endif

[hw/rtl/gfsb_pkg.sv]
// types and constants of the gpio function select bank
package gfsb_pkg;

    localparam int CODE_W         = 3;
    localparam int FIELDS_PER_REG = 10;
    localparam int REG_COUNT      = 6;
    localparam int FIELD_TOTAL    = REG_COUNT * FIELDS_PER_REG;
    localparam int PIN_COUNT      = 58;
    localparam int PIN_W          = 6;
    localparam int WORD_BITS      = 32;
    localparam int OP_W           = 2;
    localparam int S_TDATA_W      = 48;
    localparam int M_TDATA_W      = 40;

    typedef enum logic [OP_W-1:0] {
        OP_READ_PIN   = 2'd0,
        OP_WRITE_PIN  = 2'd1,
        OP_MATCH      = 2'd2,
        OP_WRITE_MASK = 2'd3
    } op_t;

    typedef struct packed {
        op_t                   opcode;
        logic [PIN_W-1:0]      pin;
        logic [CODE_W-1:0]     mode;
        logic                  word_select;
        logic [WORD_BITS-1:0]  pin_mask;
    } req_t;

    typedef struct packed {
        logic [CODE_W-1:0]     read_code;
        logic [WORD_BITS-1:0]  match_mask;
        logic                  bad_pin;
    } rsp_t;

endpackage

[hw/rtl/gfsb_bank.sv]
// function code storage with per-pin and per-word access logic
`include "assert_macros.svh"

module gfsb_bank (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            exec_en,
    input  gfsb_pkg::req_t  req,
    output gfsb_pkg::rsp_t  rsp
);

    logic [gfsb_pkg::CODE_W-1:0]    codes_reg [gfsb_pkg::FIELD_TOTAL];
    logic [gfsb_pkg::FIELD_TOTAL-1:0] field_we;
    logic [gfsb_pkg::WORD_BITS-1:0] match_bits;
    logic                           pin_ok;
    logic                           is_pin_op;

    assign pin_ok    = (req.pin < gfsb_pkg::PIN_W'(gfsb_pkg::PIN_COUNT));
    assign is_pin_op = (req.opcode == gfsb_pkg::OP_READ_PIN) ||
                       (req.opcode == gfsb_pkg::OP_WRITE_PIN);

    // field write enables
    for (genvar f = 0; f < gfsb_pkg::FIELD_TOTAL; f++) begin : g_field
        localparam logic WSEL = 1'(f / gfsb_pkg::WORD_BITS);
        localparam int   BIT  = f % gfsb_pkg::WORD_BITS;
        assign field_we[f] = exec_en &&
            (((req.opcode == gfsb_pkg::OP_WRITE_PIN) && pin_ok &&
              (req.pin == gfsb_pkg::PIN_W'(f))) ||
             ((req.opcode == gfsb_pkg::OP_WRITE_MASK) &&
              (req.word_select == WSEL) && req.pin_mask[BIT]));
    end

    // match compare per word bit
    for (genvar i = 0; i < gfsb_pkg::WORD_BITS; i++) begin : g_match
        if (gfsb_pkg::WORD_BITS + i < gfsb_pkg::FIELD_TOTAL) begin : g_both
            assign match_bits[i] = req.word_select ?
                (codes_reg[gfsb_pkg::WORD_BITS + i] == req.mode) :
                (codes_reg[i] == req.mode);
        end else begin : g_low
            assign match_bits[i] = !req.word_select && (codes_reg[i] == req.mode);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int f = 0; f < gfsb_pkg::FIELD_TOTAL; f++) begin
                codes_reg[f] <= '0;
            end
        end else begin
            for (int f = 0; f < gfsb_pkg::FIELD_TOTAL; f++) begin
                if (field_we[f]) begin
                    codes_reg[f] <= req.mode;
                end
            end
        end
    end

    always_comb begin
        rsp.read_code  = '0;
        rsp.match_mask = '0;
        rsp.bad_pin    = is_pin_op && !pin_ok;
        if ((req.opcode == gfsb_pkg::OP_READ_PIN) && pin_ok) begin
            rsp.read_code = codes_reg[req.pin];
        end
        if (req.opcode == gfsb_pkg::OP_MATCH) begin
            rsp.match_mask = match_bits;
        end
    end

    `ASSERT_NEVER(a_bad_pin_no_write, aclk, aresetn,
        exec_en && is_pin_op && !pin_ok && (field_we != '0),
        "out of range pin operation changed a field")
    `ASSERT_CLK(a_pin_write_single, aclk, aresetn,
        (exec_en && (req.opcode == gfsb_pkg::OP_WRITE_PIN) && pin_ok) |->
            $onehot(field_we),
        "pin write must touch exactly one field")
    `ASSERT_CLK(a_pin_write_lands, aclk, aresetn,
        (exec_en && (req.opcode == gfsb_pkg::OP_WRITE_PIN) && pin_ok) |=>
            (codes_reg[$past(req.pin)] == $past(req.mode)),
        "pin write not stored")

endmodule

[hw/rtl/gpio_function_select_bank.sv]
// gpio function select bank top level with stream handshake and result register
//
// input transactions on the s_ channel carry one operation each: the opcode in
// s_tuser selects pin read, pin write, match mask query or write by mask, and
// s_tdata holds pin, mode, word_select and pin_mask. every accepted transaction
// gives exactly one result transaction on the m_ channel, with read_code and
// match_mask in m_tdata and bad_pin in m_tuser.
// an accepted transaction lands in an input register, is executed against the
// 60 field code registers and its result is captured in the output register.
// one transaction per cycle is sustained while m_tready is high; the field
// registers are updated in the same cycle the result is captured, so the next
// transaction sees them.
// when m_tready is low the result holds, the input register holds one more
// transaction and s_tready drops once both are full.
// aresetn (synchronous, active low) clears all function codes to zero (input
// mode) and empties both registers.
`include "assert_macros.svh"

module gpio_function_select_bank (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pin[5:0], mode[8:6], word_select[9], pin_mask[41:10], zero fill
    input  logic [gfsb_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode[1:0]
    input  logic [gfsb_pkg::OP_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_code[2:0], match_mask[34:3], zero fill
    output logic [gfsb_pkg::M_TDATA_W-1:0]  m_tdata,
    // bad_pin
    output logic                            m_tuser
);

    logic            in_valid_reg;
    logic            in_valid_next;
    gfsb_pkg::req_t  req_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    gfsb_pkg::rsp_t  rsp_reg;
    gfsb_pkg::rsp_t  rsp_comb;
    logic            advance;
    logic            exec_en;
    logic            s_fire;

    assign advance  = !out_valid_reg || m_tready;
    assign exec_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    assign in_valid_next  = s_fire || (in_valid_reg && !advance);
    assign out_valid_next = exec_en || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg.opcode      <= gfsb_pkg::op_t'(s_tuser);
            req_reg.pin         <= s_tdata[5:0];
            req_reg.mode        <= s_tdata[8:6];
            req_reg.word_select <= s_tdata[9];
            req_reg.pin_mask    <= s_tdata[41:10];
        end
        if (exec_en) begin
            rsp_reg <= rsp_comb;
        end
    end

    gfsb_bank u_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .exec_en (exec_en),
        .req     (req_reg),
        .rsp     (rsp_comb)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, rsp_reg.match_mask, rsp_reg.read_code};
    assign m_tuser  = rsp_reg.bad_pin;

    `ASSERT_CLK(a_exec_gives_result, aclk, aresetn,
        exec_en |=> out_valid_reg,
        "executed transaction produced no result")
    `ASSERT_CLK(a_stalled_input_held, aclk, aresetn,
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(req_reg)),
        "pending transaction lost during stall")
    `ASSERT_CLK(a_error_clean_result, aclk, aresetn,
        (out_valid_reg && rsp_reg.bad_pin) |->
            ((rsp_reg.read_code == '0) && (rsp_reg.match_mask == '0)),
        "range error result carries data")
    `ASSERT_NEVER(a_ready_when_empty, aclk, aresetn,
        !out_valid_reg && !s_tready,
        "input stalled with empty result register")

endmodule
